>>> rtl/rejoin_backoff_controller_assert.svh
// assertion macros used by the bound checker rbc_checker
`ifndef REJOIN_BACKOFF_CONTROLLER_ASSERT_SVH
`define REJOIN_BACKOFF_CONTROLLER_ASSERT_SVH

// antecedent implies consequent on the same edge
`define RBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent at a later edge
`define RBC_ASSERT_DELAY2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed");

// antecedent implies consequent on the next edge
`define RBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/rbc_pkg.sv
package rbc_pkg;

    localparam int DELAY_W   = 32;
    localparam int ATTEMPT_W = 5;
    localparam int REQ_W     = 3;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_PROCESS = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ARMED   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIRED   = 3'd4;

    localparam logic [ATTEMPT_W-1:0] ATTEMPT_LIMIT = 5'd31;
    localparam logic [DELAY_W-1:0]   MAX_INTERVAL_RESET = 32'd900;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             stack_ready;
        logic             joined;
        logic             cancel_ok;
    } item_t;

    typedef struct packed {
        logic               started_note;
        logic               stopped_note;
        logic               retry_due;
        logic               stop_parked;
        logic [DELAY_W-1:0] retry_delay;
    } result_t;

endpackage

>>> rtl/rejoin_backoff_controller.sv
// an accepted item goes to the input register, its result to the result register
// throughput: one item per cycle while the output does not stall, set by the state update
// between the input register and the result register
// reset: asynchronous, clears control state and loads max_interval_s with 900
module rejoin_backoff_controller
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] stack_ready, [1] joined, [2] cancel_ok, rest zero
    input  logic [rbc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] req_type
    input  logic [rbc_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] started_note, [1] stopped_note, [2] retry_due, [3] stop_parked,
    // [35:4] retry_delay, rest zero
    output logic [rbc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rbc_pkg::DELAY_W-1:0]      cfg_data
);
    import rbc_pkg::*;

    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    logic [DELAY_W-1:0] max_interval_reg;
    logic               advance;
    result_t            res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    rbc_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .item           (in_item_reg),
        .max_interval_s (max_interval_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            max_interval_reg <= MAX_INTERVAL_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                max_interval_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.req_type    <= s_axis_tuser;
            in_item_reg.stack_ready <= s_axis_tdata[0];
            in_item_reg.joined      <= s_axis_tdata[1];
            in_item_reg.cancel_ok   <= s_axis_tdata[2];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W-DELAY_W-4)'(0),
                            out_res_reg.retry_delay,
                            out_res_reg.stop_parked,
                            out_res_reg.retry_due,
                            out_res_reg.stopped_note,
                            out_res_reg.started_note};

endmodule

>>> rtl/rbc_core.sv
module rbc_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  rbc_pkg::item_t               item,
    input  logic [rbc_pkg::DELAY_W-1:0]  max_interval_s,
    output rbc_pkg::result_t             res
);
    import rbc_pkg::*;

    logic                 active_reg, active_next;
    logic                 stop_pending_reg, stop_pending_next;
    logic                 retry_armed_reg, retry_armed_next;
    logic [ATTEMPT_W-1:0] attempts_reg, attempts_next;

    always_comb
    begin
        logic               run_p;
        logic [DELAY_W-1:0] pow;
        active_next       = active_reg;
        stop_pending_next = stop_pending_reg;
        retry_armed_next  = retry_armed_reg;
        attempts_next     = attempts_reg;
        res               = '0;
        run_p             = 1'b0;
        pow               = '0;
        case (item.req_type)
            REQ_PROCESS:
            begin
                run_p = 1'b1;
            end
            REQ_START:
            begin
                if (item.stack_ready && !item.joined)
                begin
                    run_p = 1'b1;
                    if (!active_reg)
                    begin
                        active_next       = 1'b1;
                        stop_pending_next = 1'b0;
                        retry_armed_next  = 1'b0;
                        attempts_next     = '0;
                        res.started_note  = 1'b1;
                    end
                end
            end
            REQ_STOP:
            begin
                if (active_reg)
                begin
                    if (item.cancel_ok)
                    begin
                        active_next       = 1'b0;
                        stop_pending_next = 1'b0;
                        retry_armed_next  = 1'b0;
                        attempts_next     = '0;
                        res.stopped_note  = 1'b1;
                    end
                    else
                    begin
                        stop_pending_next = 1'b1;
                        res.stop_parked   = 1'b1;
                    end
                end
            end
            REQ_ARMED:
            begin
                retry_armed_next = 1'b1;
            end
            REQ_FIRED:
            begin
                retry_armed_next = 1'b0;
            end
            default:
            begin
                run_p = 1'b0;
            end
        endcase

        // process evaluation, also run after a start
        if (run_p && item.stack_ready && active_next)
        begin
            if (stop_pending_next)
            begin
                active_next       = 1'b0;
                stop_pending_next = 1'b0;
                retry_armed_next  = 1'b0;
                attempts_next     = '0;
                res.stopped_note  = 1'b1;
            end
            else if (!retry_armed_next && !item.joined)
            begin
                res.retry_due = 1'b1;
                pow = DELAY_W'(1) << attempts_next;
                if (attempts_next == ATTEMPT_LIMIT)
                begin
                    res.retry_delay = max_interval_s;
                end
                else if (pow > max_interval_s)
                begin
                    res.retry_delay = max_interval_s;
                end
                else
                begin
                    res.retry_delay = pow;
                    attempts_next   = attempts_next + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            stop_pending_reg <= 1'b0;
            retry_armed_reg  <= 1'b0;
            attempts_reg     <= '0;
        end
        else if (fire)
        begin
            active_reg       <= active_next;
            stop_pending_reg <= stop_pending_next;
            retry_armed_reg  <= retry_armed_next;
            attempts_reg     <= attempts_next;
        end
    end

endmodule

>>> rtl/rbc_checker.sv
`include "rejoin_backoff_controller_assert.svh"

module rbc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rbc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rbc_pkg::*;

    // output valid follows each accepted item via the input register
    `RBC_ASSERT_DELAY2(a_in_to_out, clk, rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    // stopped, scheduled and deferred never come together
    `RBC_ASSERT_IMPLY(a_excl_flags, clk, rst_n, m_axis_tvalid, $onehot0(m_axis_tdata[3:1]))
    // delay is zero unless a retry is scheduled
    `RBC_ASSERT_IMPLY(a_zero_delay, clk, rst_n, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[35:4] == 32'd0)
    // a stalled result stays valid
    `RBC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind rejoin_backoff_controller rbc_checker u_rbc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/rejoin_backoff_checker.sv
`timescale 1ns / 1ps

module rejoin_backoff_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // [0] stack_ready, [1] joined, [2] cancel_ok, rest zero
    input  logic [rbc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] req_type
    input  logic [rbc_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] started_note, [1] stopped_note, [2] retry_due, [3] stop_parked,
    // [35:4] retry_delay, rest zero
    input  logic [rbc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [rbc_pkg::DELAY_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            outstanding,
    output int                            results_checked
);
    import rbc_pkg::*;

    logic                 proc_active;
    logic                 stop_held;
    logic                 retry_held;
    logic [ATTEMPT_W-1:0] attempt_cnt;
    logic [DELAY_W-1:0]   delay_cap;
    result_t              expected_results[$];

    task automatic clear_rejoin();
        proc_active = 1'b0;
        stop_held   = 1'b0;
        retry_held  = 1'b0;
        attempt_cnt = '0;
    endtask

    // backoff evaluation shared by process and start events
    task automatic evaluate_backoff(input logic ready, input logic is_joined,
                                    inout result_t r);
        logic [DELAY_W-1:0] delay;
        if (ready && proc_active)
        begin
            if (stop_held)
            begin
                clear_rejoin();
                r.stopped_note = 1'b1;
            end
            else if (!retry_held && !is_joined)
            begin
                if (attempt_cnt == ATTEMPT_LIMIT)
                begin
                    delay = delay_cap;
                end
                else
                begin
                    delay = '0;
                    delay[attempt_cnt] = 1'b1;
                    if (delay > delay_cap)
                        delay = delay_cap;
                    else
                        attempt_cnt = attempt_cnt + 1'b1;
                end
                r.retry_due   = 1'b1;
                r.retry_delay = delay;
            end
        end
    endtask

    task automatic predict_rejoin(input item_t ev, output result_t r);
        r = '0;
        case (ev.req_type)
            REQ_PROCESS:
            begin
                evaluate_backoff(ev.stack_ready, ev.joined, r);
            end
            REQ_START:
            begin
                if (ev.stack_ready && !ev.joined)
                begin
                    if (!proc_active)
                    begin
                        clear_rejoin();
                        proc_active    = 1'b1;
                        r.started_note = 1'b1;
                    end
                    evaluate_backoff(ev.stack_ready, ev.joined, r);
                end
            end
            REQ_STOP:
            begin
                if (proc_active)
                begin
                    if (ev.cancel_ok)
                    begin
                        clear_rejoin();
                        r.stopped_note = 1'b1;
                    end
                    else
                    begin
                        stop_held     = 1'b1;
                        r.stop_parked = 1'b1;
                    end
                end
            end
            REQ_ARMED:
            begin
                retry_held = 1'b1;
            end
            REQ_FIRED:
            begin
                retry_held = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [DELAY_W-1:0] want,
                                 input logic [DELAY_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   ev;
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            clear_rejoin();
            delay_cap = MAX_INTERVAL_RESET;
            expected_results.delete();
            fail_count      = 0;
            results_checked = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expected item: tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    compare_field("started_note", DELAY_W'(want.started_note),
                                  DELAY_W'(m_axis_tdata[0]));
                    compare_field("stopped_note", DELAY_W'(want.stopped_note),
                                  DELAY_W'(m_axis_tdata[1]));
                    compare_field("retry_due", DELAY_W'(want.retry_due),
                                  DELAY_W'(m_axis_tdata[2]));
                    compare_field("stop_parked", DELAY_W'(want.stop_parked),
                                  DELAY_W'(m_axis_tdata[3]));
                    compare_field("retry_delay", want.retry_delay, m_axis_tdata[35:4]);
                    compare_field("padding", '0, DELAY_W'(m_axis_tdata[M_TDATA_W-1:36]));
                end
            end
            if (cfg_valid && cfg_ready)
                delay_cap = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                ev.req_type    = s_axis_tuser[REQ_W-1:0];
                ev.stack_ready = s_axis_tdata[0];
                ev.joined      = s_axis_tdata[1];
                ev.cancel_ok   = s_axis_tdata[2];
                predict_rejoin(ev, fresh);
                expected_results.push_back(fresh);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rbc_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [0] stack_ready, [1] joined, [2] cancel_ok, rest zero
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // [2:0] req_type
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [0] started_note, [1] stopped_note, [2] retry_due, [3] stop_parked,
    // [35:4] retry_delay, rest zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [DELAY_W-1:0]   cfg_data = '0;

    int   tx_idle_pct = 22;
    int   rx_idle_pct = 80;
    logic hold_rx = 1'b0;
    int   events_sent = 0;
    int   fail_count;
    int   outstanding;
    int   results_checked;

    rejoin_backoff_controller dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    rejoin_backoff_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("rejoin_backoff_controller regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic coin();
        return $urandom_range(0, 1) == 1;
    endfunction

    function automatic item_t make_event(input logic [REQ_W-1:0] req, input logic ready,
                                         input logic is_joined, input logic cancel);
        item_t ev;
        ev.req_type    = req;
        ev.stack_ready = ready;
        ev.joined      = is_joined;
        ev.cancel_ok   = cancel;
        return ev;
    endfunction

    function automatic item_t noise_event();
        logic [REQ_W-1:0] req;
        if ($urandom_range(0, 99) < 90)
            req = REQ_W'($urandom_range(REQ_PROCESS, REQ_FIRED));
        else
            req = REQ_W'($urandom_range(REQ_FIRED + 1, 7));
        return make_event(req, coin(), coin(), coin());
    endfunction

    task automatic send_event(input item_t ev);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-3){1'b0}}, ev.cancel_ok, ev.joined, ev.stack_ready};
        s_axis_tuser  <= ev.req_type;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        events_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_cap(input logic [DELAY_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // start, a run of mostly clean process events, maybe a stop, then noise
    task automatic run_rejoin_burst();
        int len;
        int pick;
        len = $urandom_range(4, 40);
        send_event(make_event(REQ_START, 1'b1, 1'b0, coin()));
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_event(make_event(REQ_ARMED, coin(), coin(), coin()));
            else if (pick < 10)
                send_event(make_event(REQ_FIRED, coin(), coin(), coin()));
            else if (pick < 15)
                send_event(make_event(REQ_PROCESS, coin(), coin(), coin()));
            else
                send_event(make_event(REQ_PROCESS, 1'b1, 1'b0, coin()));
        end
        if (coin())
            send_event(make_event(REQ_STOP, coin(), coin(), coin()));
        repeat ($urandom_range(0, 5))
            send_event(noise_event());
    endtask

    initial
    begin
        logic [DELAY_W-1:0] caps [5];
        int                 phase_start;
        caps[0] = 32'hFFFF_FFFF;
        caps[1] = 32'h0;
        caps[2] = $urandom();
        caps[3] = 32'd1;
        caps[4] = $urandom_range(2, 2000);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed events at the reset cap
        send_event(make_event(REQ_PROCESS, 1'b1, 1'b0, 1'b1));
        send_event(make_event(REQ_STOP, 1'b1, 1'b0, 1'b1));
        send_event(make_event(REQ_START, 1'b0, 1'b0, 1'b0));
        send_event(make_event(REQ_START, 1'b1, 1'b1, 1'b0));
        send_event(make_event(REQ_START, 1'b1, 1'b0, 1'b0));
        send_event(make_event(REQ_START, 1'b1, 1'b0, 1'b1));
        send_event(make_event(REQ_ARMED, 1'b0, 1'b0, 1'b0));
        send_event(make_event(REQ_PROCESS, 1'b1, 1'b0, 1'b0));
        send_event(make_event(REQ_FIRED, 1'b1, 1'b1, 1'b1));
        send_event(make_event(REQ_PROCESS, 1'b1, 1'b1, 1'b0));
        send_event(make_event(REQ_PROCESS, 1'b0, 1'b0, 1'b0));
        send_event(make_event(REQ_PROCESS, 1'b1, 1'b0, 1'b1));
        send_event(make_event(REQ_STOP, 1'b0, 1'b1, 1'b0));
        send_event(make_event(REQ_PROCESS, 1'b1, 1'b1, 1'b1));
        send_event(make_event(REQ_START, 1'b1, 1'b0, 1'b0));
        send_event(make_event(REQ_STOP, 1'b1, 1'b1, 1'b1));
        send_event(make_event(REQ_START, 1'b1, 1'b0, 1'b1));
        send_event(make_event(REQ_STOP, 1'b1, 1'b0, 1'b0));
        send_event(make_event(REQ_START, 1'b1, 1'b0, 1'b0));
        send_event(make_event(REQ_FIRED + 3'd1, 1'b1, 1'b1, 1'b1));
        send_event(make_event(REQ_FIRED + 3'd2, 1'b0, 1'b0, 1'b0));
        send_event(make_event(REQ_FIRED + 3'd3, 1'b1, 1'b1, 1'b1));
        send_event(make_event(REQ_START, 1'b1, 1'b0, 1'b0));
        send_event(make_event(REQ_PROCESS, 1'b1, 1'b0, 1'b0));

        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            tx_idle_pct = (p < 2) ? 22 : (p < 4) ? 80 : 0;
            rx_idle_pct = (p < 2) ? 80 : (p < 4) ? 22 : 0;
            write_cap(caps[p]);
            if (p == 4)
            begin
                // long receiver stall so the block backs up into its input
                fork
                    begin
                        hold_rx <= 1'b1;
                        repeat (200) @(posedge clk);
                        hold_rx <= 1'b0;
                    end
                join_none
            end
            phase_start = events_sent;
            while (events_sent - phase_start < 250)
                run_rejoin_burst();
        end
        wait_drained();

        $display("covered %0d events and %0d results over six delay caps", events_sent,
                 results_checked);
        $display("caps included all ones, zero and one; long output stall included");
        if (fail_count == 0)
            $display("rejoin_backoff_controller regression: pass");
        else
            $display("rejoin_backoff_controller regression: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/rbc_pkg.sv
rtl/rbc_core.sv
rtl/rejoin_backoff_controller.sv
rtl/rbc_checker.sv
bench/rejoin_backoff_checker.sv
bench/testbench.sv
